[rtl/core/sc1a_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sc1a_pkg
// Shared types, scan codes and character tables for the set 1 keyboard decoder.
// ----------------------------------------------------------------------------
package sc1a_pkg;

  localparam int unsigned LINE_CAPACITY_DEF = 128;
  localparam int unsigned COUNT_W = 7;
  localparam int unsigned CHAR_W = 7;
  localparam int unsigned TERM_W = 2;
  localparam int unsigned KIND_W = 4;
  localparam int unsigned SCAN_W = 8;
  localparam int unsigned OUT_DATA_W = 16;

  localparam logic [SCAN_W-1:0] SC_LIMIT      = 8'hD8;
  localparam logic [SCAN_W-1:0] SC_BACKSPACE  = 8'h0E;
  localparam logic [SCAN_W-1:0] SC_TAB        = 8'h0F;
  localparam logic [SCAN_W-1:0] SC_ENTER      = 8'h1C;
  localparam logic [SCAN_W-1:0] SC_CTRL       = 8'h1D;
  localparam logic [SCAN_W-1:0] SC_LSHIFT     = 8'h2A;
  localparam logic [SCAN_W-1:0] SC_RSHIFT     = 8'h36;
  localparam logic [SCAN_W-1:0] SC_ALT        = 8'h38;
  localparam logic [SCAN_W-1:0] SC_CAPS       = 8'h3A;
  localparam logic [SCAN_W-1:0] SC_F1         = 8'h3B;
  localparam logic [SCAN_W-1:0] SC_F2         = 8'h3C;
  localparam logic [SCAN_W-1:0] SC_F3         = 8'h3D;
  localparam logic [SCAN_W-1:0] SC_UP         = 8'h48;
  localparam logic [SCAN_W-1:0] SC_DOWN       = 8'h50;
  localparam logic [SCAN_W-1:0] SC_KEY_L      = 8'h26;
  localparam logic [SCAN_W-1:0] SC_KEY_C      = 8'h2E;
  localparam logic [SCAN_W-1:0] SC_CTRL_REL   = 8'h9D;
  localparam logic [SCAN_W-1:0] SC_LSHIFT_REL = 8'hAA;
  localparam logic [SCAN_W-1:0] SC_RSHIFT_REL = 8'hB6;
  localparam logic [SCAN_W-1:0] SC_ALT_REL    = 8'hB8;

  localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 7'h0A;
  localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 7'd65;
  localparam logic [CHAR_W-1:0] CHAR_UPPER_Z = 7'd90;

  localparam logic [TERM_W-1:0] TERM_0 = 2'd0;
  localparam logic [TERM_W-1:0] TERM_1 = 2'd1;
  localparam logic [TERM_W-1:0] TERM_2 = 2'd2;

  typedef enum logic [KIND_W-1:0] {
    EV_CHAR     = 4'd0,
    EV_ERASE    = 4'd1,
    EV_LINE_END = 4'd2,
    EV_CLEAR    = 4'd3,
    EV_CANCEL   = 4'd4,
    EV_SWITCH   = 4'd5,
    EV_UP       = 4'd6,
    EV_DOWN     = 4'd7,
    EV_COMPLETE = 4'd8
  } event_kind_e;

  typedef struct packed {
    logic               ctrl_held;
    logic               shift_held;
    logic               alt_held;
    logic               caps_on;
    logic [COUNT_W-1:0] line_count;
  } key_state_t;

  typedef struct packed {
    event_kind_e        event_kind;
    logic [CHAR_W-1:0]  char_code;
    logic [TERM_W-1:0]  term_index;
    logic [COUNT_W-1:0] line_length;
  } result_t;

  localparam logic [CHAR_W-1:0] PLAIN_TAB [64] = '{
    7'h00, 7'h00, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
    7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h3D, 7'h00, 7'h00,
    7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
    7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00, 7'h61, 7'h73,
    7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
    7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76,
    7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h00,
    7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
  };

  localparam logic [CHAR_W-1:0] UPPER_TAB [64] = '{
    7'h00, 7'h00, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E,
    7'h26, 7'h2A, 7'h28, 7'h29, 7'h5F, 7'h2B, 7'h00, 7'h00,
    7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
    7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00, 7'h41, 7'h53,
    7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
    7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56,
    7'h42, 7'h4E, 7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h00,
    7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
  };

endpackage
`default_nettype wire

[rtl/core/sc1a_decode.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sc1a_decode
// Turns one scan code and the current key state into the next key state and
// an optional result.
// ----------------------------------------------------------------------------
module sc1a_decode
  import sc1a_pkg::*;
#(
  parameter int unsigned LineCapacity = LINE_CAPACITY_DEF
) (
  input  logic [SCAN_W-1:0] scan_byte_i,
  input  key_state_t        state_i,
  output key_state_t        state_o,
  output logic              res_valid_o,
  output result_t           result_o
);

  localparam logic [COUNT_W-1:0] LineMax = COUNT_W'(LineCapacity - 1);

  logic [5:0]        pos;
  logic [CHAR_W-1:0] plain_ch;
  logic [CHAR_W-1:0] upper_ch;
  logic              alpha;
  logic [CHAR_W-1:0] ch;

  assign pos      = scan_byte_i[5:0];
  assign plain_ch = PLAIN_TAB[pos];
  assign upper_ch = UPPER_TAB[pos];
  assign alpha    = (upper_ch >= CHAR_UPPER_A) && (upper_ch <= CHAR_UPPER_Z);
  assign ch       = (state_i.shift_held ^ (state_i.caps_on & alpha)) ? upper_ch : plain_ch;

  always_comb begin
    state_o                = state_i;
    res_valid_o            = 1'b0;
    result_o.event_kind    = EV_CHAR;
    result_o.char_code     = '0;
    result_o.term_index    = TERM_0;
    if (scan_byte_i <= SC_LIMIT) begin
      case (scan_byte_i)
        SC_CTRL:                  state_o.ctrl_held  = 1'b1;
        SC_CTRL_REL:              state_o.ctrl_held  = 1'b0;
        SC_LSHIFT, SC_RSHIFT:     state_o.shift_held = 1'b1;
        SC_LSHIFT_REL, SC_RSHIFT_REL: state_o.shift_held = 1'b0;
        SC_ALT:                   state_o.alt_held   = 1'b1;
        SC_ALT_REL:               state_o.alt_held   = 1'b0;
        SC_CAPS:                  state_o.caps_on    = ~state_i.caps_on;
        SC_ENTER: begin
          state_o.line_count = '0;
          res_valid_o        = 1'b1;
          result_o.event_kind = EV_LINE_END;
          result_o.char_code  = CHAR_NEWLINE;
        end
        SC_TAB: begin
          res_valid_o         = 1'b1;
          result_o.event_kind = EV_COMPLETE;
        end
        SC_UP: begin
          res_valid_o         = 1'b1;
          result_o.event_kind = EV_UP;
        end
        SC_DOWN: begin
          res_valid_o         = 1'b1;
          result_o.event_kind = EV_DOWN;
        end
        SC_BACKSPACE: begin
          if (state_i.line_count != '0) begin
            state_o.line_count  = state_i.line_count - COUNT_W'(1);
            res_valid_o         = 1'b1;
            result_o.event_kind = EV_ERASE;
          end
        end
        default: begin
          if (scan_byte_i[7:6] == 2'b00) begin
            if (state_i.ctrl_held) begin
              if (scan_byte_i == SC_KEY_L) begin
                res_valid_o         = 1'b1;
                result_o.event_kind = EV_CLEAR;
              end else if (scan_byte_i == SC_KEY_C) begin
                res_valid_o         = 1'b1;
                result_o.event_kind = EV_CANCEL;
              end
            end else if (state_i.alt_held) begin
              if (scan_byte_i == SC_F1) begin
                res_valid_o         = 1'b1;
                result_o.event_kind = EV_SWITCH;
                result_o.term_index = TERM_0;
              end else if (scan_byte_i == SC_F2) begin
                res_valid_o         = 1'b1;
                result_o.event_kind = EV_SWITCH;
                result_o.term_index = TERM_1;
              end else if (scan_byte_i == SC_F3) begin
                res_valid_o         = 1'b1;
                result_o.event_kind = EV_SWITCH;
                result_o.term_index = TERM_2;
              end
            end else if ((ch != '0) && (state_i.line_count < LineMax)) begin
              state_o.line_count  = state_i.line_count + COUNT_W'(1);
              res_valid_o         = 1'b1;
              result_o.event_kind = EV_CHAR;
              result_o.char_code  = ch;
            end
          end
        end
      endcase
    end
    result_o.line_length = state_o.line_count;
  end

endmodule
`default_nettype wire

[rtl/core/sc1a_out_reg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sc1a_out_reg
// Result register on the output stream; frees itself whenever the consumer
// takes the held result.
// ----------------------------------------------------------------------------
module sc1a_out_reg
  import sc1a_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,
  input  result_t result_i,
  output logic    free_o,
  output logic    valid_o,
  input  logic    ready_i,
  output result_t result_o
);

  logic    valid_q, valid_d;
  result_t data_q, data_d;

  assign free_o = ~valid_q | ready_i;

  always_comb begin
    valid_d = valid_q & ~ready_i;
    data_d  = data_q;
    if (load_i) begin
      valid_d = 1'b1;
      data_d  = result_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign valid_o  = valid_q;
  assign result_o = data_q;

endmodule
`default_nettype wire

[rtl/core/scancode_set1_to_ascii.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// scancode_set1_to_ascii
// Decodes scan code set 1 bytes into ASCII characters and line editing events.
// ----------------------------------------------------------------------------
// Channel   Dir  Payload
// s_axis    in   tdata[7:0] scan_byte
// m_axis    out  tuser[3:0] event_kind; tdata char_code, term_index, line_length
//
// A request is registered on input, decoded combinationally and lands in
// the result register. One request is accepted per cycle; both stages
// advance together and stall only while the result register is full and
// m_axis_tready is low.
// Reset clears the modifier flags, caps lock and the line count.
// ----------------------------------------------------------------------------
module scancode_set1_to_ascii
  import sc1a_pkg::*;
#(
  parameter int unsigned LineCapacity = LINE_CAPACITY_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [SCAN_W-1:0]     s_axis_tdata,   // [7:0] scan_byte
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,   // [6:0] char_code, [8:7] term_index,
                                                // [15:9] line_length
  output logic [KIND_W-1:0]     m_axis_tuser    // [3:0] event_kind
);

  logic              in_valid_q, in_valid_d;
  logic [SCAN_W-1:0] in_byte_q, in_byte_d;
  key_state_t        state_q, state_d;
  key_state_t        dec_state;
  logic              dec_valid;
  result_t           dec_result;
  result_t           out_result;
  logic              advance;
  logic              take;

  assign s_axis_tready = ~in_valid_q | advance;
  assign take          = in_valid_q & advance;

  sc1a_decode #(
    .LineCapacity(LineCapacity)
  ) u_decode (
    .scan_byte_i(in_byte_q),
    .state_i    (state_q),
    .state_o    (dec_state),
    .res_valid_o(dec_valid),
    .result_o   (dec_result)
  );

  sc1a_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (take & dec_valid),
    .result_i(dec_result),
    .free_o  (advance),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .result_o(out_result)
  );

  always_comb begin
    in_valid_d = in_valid_q & ~advance;
    in_byte_d  = in_byte_q;
    if (s_axis_tvalid && s_axis_tready) begin
      in_valid_d = 1'b1;
      in_byte_d  = s_axis_tdata;
    end
    state_d = take ? dec_state : state_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      state_q    <= '0;
    end else begin
      in_valid_q <= in_valid_d;
      state_q    <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_byte_q <= in_byte_d;
  end

  assign m_axis_tuser = out_result.event_kind;
  assign m_axis_tdata = {out_result.line_length, out_result.term_index, out_result.char_code};

endmodule
`default_nettype wire

[bench/scancode_set1_to_ascii_tb.sv]
// ----------------------------------------------------------------------------
// scancode_set1_to_ascii_tb
// Self-checking bench for the set 1 scan code decoder. Scan bytes go in on the
// slave stream and the decoded events come out on the master stream. A
// scoreboard tracks the modifier keys, caps lock and the line count, predicts
// each event and compares it field by field with what the decoder returns.
// Directed keystrokes come first, then random typing, editing, modifier
// chords and noise under varying backpressure.
// ----------------------------------------------------------------------------
module scancode_set1_to_ascii_tb;
  import sc1a_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RANDOM_ITEMS = 1000;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam logic [SCAN_W-1:0] KEY_RELEASE  = 8'h80;
  localparam logic [SCAN_W-1:0] KEY_CODE_END = 8'h40;

  localparam int unsigned DIRECTED_N = 34;
  localparam logic [SCAN_W-1:0] DIRECTED_CODES [DIRECTED_N] = '{
    8'h00, 8'hFF, 8'hD9, 8'hD8, 8'h1E, SC_LSHIFT, 8'h1E, 8'h02, SC_LSHIFT_REL,
    SC_CAPS, 8'h1E, SC_RSHIFT, 8'h1E, 8'h02, SC_RSHIFT_REL, SC_CAPS, SC_F1,
    8'h47, SC_BACKSPACE, SC_TAB, SC_UP, SC_DOWN, SC_ENTER, SC_BACKSPACE,
    SC_CTRL, SC_KEY_L, SC_KEY_C, SC_ALT, SC_F1, SC_CTRL_REL, SC_F2, SC_F3,
    SC_ALT_REL, 8'h9E
  };

  class keystroke_predictor;
    key_state_t  keys;
    result_t     pending_events[$];
    int unsigned failures;
    int unsigned accepted_scans;

    function new();
      keys = '0;
      failures = 0;
      accepted_scans = 0;
    endfunction

    function void note_scan(logic [SCAN_W-1:0] code);
      result_t           ev;
      logic [CHAR_W-1:0] ch;
      logic [CHAR_W-1:0] lo;
      logic [CHAR_W-1:0] up;
      logic [5:0]        pos;
      bit                emit;
      bit                alpha;
      accepted_scans++;
      ev = '0;
      ev.event_kind = EV_CHAR;
      emit = 1'b0;
      if (code > SC_LIMIT) return;
      case (code)
        SC_CTRL:                      keys.ctrl_held = 1'b1;
        SC_CTRL_REL:                  keys.ctrl_held = 1'b0;
        SC_LSHIFT, SC_RSHIFT:         keys.shift_held = 1'b1;
        SC_LSHIFT_REL, SC_RSHIFT_REL: keys.shift_held = 1'b0;
        SC_ALT:                       keys.alt_held = 1'b1;
        SC_ALT_REL:                   keys.alt_held = 1'b0;
        SC_CAPS:                      keys.caps_on = ~keys.caps_on;
        SC_ENTER: begin
          keys.line_count = '0;
          ev.event_kind = EV_LINE_END;
          ev.char_code = CHAR_NEWLINE;
          emit = 1'b1;
        end
        SC_TAB: begin
          ev.event_kind = EV_COMPLETE;
          emit = 1'b1;
        end
        SC_UP: begin
          ev.event_kind = EV_UP;
          emit = 1'b1;
        end
        SC_DOWN: begin
          ev.event_kind = EV_DOWN;
          emit = 1'b1;
        end
        SC_BACKSPACE: begin
          if (keys.line_count != '0) begin
            keys.line_count = keys.line_count - 1'b1;
            ev.event_kind = EV_ERASE;
            emit = 1'b1;
          end
        end
        default: begin
          if (code < KEY_CODE_END) begin
            pos = code[5:0];
            if (keys.ctrl_held) begin
              if (code == SC_KEY_L) begin
                ev.event_kind = EV_CLEAR;
                emit = 1'b1;
              end else if (code == SC_KEY_C) begin
                ev.event_kind = EV_CANCEL;
                emit = 1'b1;
              end
            end else if (keys.alt_held) begin
              if (code == SC_F1 || code == SC_F2 || code == SC_F3) begin
                ev.event_kind = EV_SWITCH;
                ev.term_index = (code == SC_F1) ? TERM_0 : (code == SC_F2) ? TERM_1 : TERM_2;
                emit = 1'b1;
              end
            end else begin
              lo = PLAIN_TAB[pos];
              up = UPPER_TAB[pos];
              alpha = (up >= CHAR_UPPER_A) && (up <= CHAR_UPPER_Z);
              if (keys.caps_on && keys.shift_held) ch = alpha ? lo : up;
              else if (keys.caps_on) ch = alpha ? up : lo;
              else if (keys.shift_held) ch = up;
              else ch = lo;
              if (ch != '0 && keys.line_count < LINE_CAPACITY_DEF - 1) begin
                keys.line_count = keys.line_count + 1'b1;
                ev.char_code = ch;
                emit = 1'b1;
              end
            end
          end
        end
      endcase
      if (emit) begin
        ev.line_length = keys.line_count;
        pending_events.push_back(ev);
      end
    endfunction

    function void check_event(result_t got);
      result_t want;
      if (pending_events.size() == 0) begin
        $error("unexpected event: kind %0d char %0h", got.event_kind, got.char_code);
        failures++;
        return;
      end
      want = pending_events.pop_front();
      if (got.event_kind !== want.event_kind) begin
        $error("event_kind: expected %0d, actual %0d", want.event_kind, got.event_kind);
        failures++;
      end
      if (got.char_code !== want.char_code) begin
        $error("char_code: expected %0h, actual %0h", want.char_code, got.char_code);
        failures++;
      end
      if (got.term_index !== want.term_index) begin
        $error("term_index: expected %0d, actual %0d", want.term_index, got.term_index);
        failures++;
      end
      if (got.line_length !== want.line_length) begin
        $error("line_length: expected %0d, actual %0d", want.line_length, got.line_length);
        failures++;
      end
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [SCAN_W-1:0]     s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [KIND_W-1:0]     m_axis_tuser;

  int unsigned         send_idle_pct = 0;
  int unsigned         recv_idle_pct = 0;
  int unsigned         cycle_count = 0;
  keystroke_predictor  predictor = new();
  result_t             seen_event;

  scancode_set1_to_ascii u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("TEST FAILED");
    $finish;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) predictor.note_scan(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) begin
        seen_event.event_kind  = event_kind_e'(m_axis_tuser);
        seen_event.char_code   = m_axis_tdata[6:0];
        seen_event.term_index  = m_axis_tdata[8:7];
        seen_event.line_length = m_axis_tdata[15:9];
        predictor.check_event(seen_event);
      end
    end
  end

  task automatic send_scan(input logic [SCAN_W-1:0] code);
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= code;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic drain_events();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (predictor.pending_events.size() != 0);
  endtask

  initial begin
    int unsigned       r;
    int unsigned       n;
    int unsigned       phase;
    int unsigned       last_phase;
    bit                first_seq;
    logic [SCAN_W-1:0] mod;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 33;
    recv_idle_pct = 79;
    foreach (DIRECTED_CODES[i]) send_scan(DIRECTED_CODES[i]);
    drain_events();

    last_phase = 0;
    first_seq = 1'b1;
    predictor.accepted_scans = 0;
    while (predictor.accepted_scans < RANDOM_ITEMS) begin
      phase = predictor.accepted_scans * 3 / RANDOM_ITEMS;
      if (phase != last_phase) begin
        drain_events();
        last_phase = phase;
      end
      case (phase)
        0: begin
          send_idle_pct = 33;
          recv_idle_pct = 79;
        end
        1: begin
          send_idle_pct = 79;
          recv_idle_pct = 33;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      r = first_seq ? 90 : $urandom_range(99);
      first_seq = 1'b0;
      if (r < 40) begin
        mod = $urandom_range(1) ? SC_LSHIFT : SC_RSHIFT;
        if ($urandom_range(1)) send_scan(mod);
        n = $urandom_range(1, 8);
        repeat (n) send_scan(SCAN_W'($urandom_range(0, KEY_CODE_END - 1)));
        if ($urandom_range(4) != 0) send_scan(mod | KEY_RELEASE);
      end else if (r < 50) begin
        if ($urandom_range(4) == 0) send_scan(SC_ALT);
        send_scan(SC_CTRL);
        case ($urandom_range(2))
          0: send_scan(SC_KEY_L);
          1: send_scan(SC_KEY_C);
          default: send_scan(SCAN_W'($urandom_range(0, KEY_CODE_END - 1)));
        endcase
        send_scan(SC_CTRL_REL);
        send_scan(SC_ALT_REL);
      end else if (r < 58) begin
        send_scan(SC_ALT);
        case ($urandom_range(3))
          0: send_scan(SC_F1);
          1: send_scan(SC_F2);
          2: send_scan(SC_F3);
          default: send_scan(SCAN_W'($urandom_range(0, KEY_CODE_END - 1)));
        endcase
        send_scan(SC_ALT_REL);
      end else if (r < 63) begin
        send_scan(SC_CAPS);
      end else if (r < 78) begin
        case ($urandom_range(7))
          0: send_scan(SC_ENTER);
          1, 2: repeat ($urandom_range(1, 4)) send_scan(SC_BACKSPACE);
          3: send_scan(SC_TAB);
          4: send_scan(SC_UP);
          5: send_scan(SC_DOWN);
          default: send_scan(SC_BACKSPACE);
        endcase
      end else if (r < 90) begin
        send_scan(SCAN_W'($urandom_range(0, 255)));
      end else if (r < 92) begin
        repeat (130) send_scan(SCAN_W'($urandom_range(8'h10, 8'h19)));
        repeat ($urandom_range(0, 3)) send_scan(SC_BACKSPACE);
        send_scan(SCAN_W'($urandom_range(8'h1E, 8'h26)));
        send_scan(SC_ENTER);
      end else begin
        if ($urandom_range(1)) begin
          send_scan(SCAN_W'($urandom_range(0, KEY_CODE_END - 1)) | KEY_RELEASE);
        end else begin
          send_scan(SCAN_W'($urandom_range(KEY_CODE_END, 8'h7F)));
        end
      end
    end

    drain_events();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (predictor.pending_events.size() != 0) begin
      $error("%0d events never arrived", predictor.pending_events.size());
      predictor.failures++;
    end
    if (predictor.failures == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[scancode_set1_to_ascii.f]
rtl/core/sc1a_pkg.sv
rtl/core/sc1a_decode.sv
rtl/core/sc1a_out_reg.sv
rtl/core/scancode_set1_to_ascii.sv
bench/scancode_set1_to_ascii_tb.sv
